/* rtl/text_console_writer_core_assert.svh */
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Check that a condition implies another condition in the same cycle.
`define TCW_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check that a condition implies another condition in the next cycle.
`define TCW_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/tcw_pkg.sv */
// Shared constants, codes and types of the text console writer.
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // Field widths
   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int CELL_W     = 16;
   localparam int ATTR_W     = 8;
   localparam int COLOR_W    = 4;
   localparam int CSR_IDX_W  = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Special characters and attributes
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FG = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG = 8'd1;
   localparam logic [COLOR_W-1:0]   FG_RESET = 4'd7;
   localparam logic [COLOR_W-1:0]   BG_RESET = 4'd0;

   // Classified operation
   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_RETURN,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   // One queued operation
   typedef struct packed {
      op_type             op;
      logic [CHAR_W-1:0]  ch;
      logic [ATTR_W-1:0]  attr;
      logic [ROW_W-1:0]   read_row;
      logic [COL_W-1:0]   read_col;
      logic               read_ok;
   } entry_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BK_SWEEP,
      BK_RUN,
      BK_READ
   } back_state_type;

endpackage

/* rtl/text_console_writer_core.sv */
// Top level of the text console writer: front end, queue, back end and cell store.
//
//   channel  dir  handshake                fields (low bit first)
//   req      in   req_tvalid / req_tready  tuser: cmd[1:0]
//                                          tdata: char_code[7:0] read_row[12:8]
//                                          read_col[19:13], zero pad to 24 bits
//   rsp      out  rsp_tvalid / rsp_tready  tdata: cell_value[15:0] cursor_col[22:16]
//                                          cursor_row[27:23] scrolled[28], pad to 32
//   csr      in   csr_valid / csr_ready    csr_index 0 fg_color, 1 bg_color; csr_data
//
// Put, carriage return, newline and unused commands are done as the back end takes
// them from the queue; a read then passes through BK_READ (registered memory read port).
// A scroll blanks the new bottom row (80 cells) through the write port; the rows
// themselves rotate through a base-row pointer and are never copied.
// A clear blanks all 2000 cells of the store through the write port.
// After reset the same fill runs with grey on black; req_tready stays low
// until it ends. A two-entry queue lets requests be taken while the back end works.
module text_console_writer_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // cmd
   input  logic [tcw_pkg::CMD_W-1:0]      req_tuser,
   // char_code, read_row, read_col
   input  logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cell_value, cursor_col, cursor_row, scrolled
   output logic [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]    csr_data
);
   import tcw_pkg::*;

   logic              queue_full;
   logic              init_busy;
   logic              push;
   entry_type         push_entry;
   logic              pop;
   logic              head_valid;
   entry_type         head_entry;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;
   logic [CELL_W-1:0] cell_value;
   logic [COL_W-1:0]  cursor_col;
   logic [ROW_W-1:0]  cursor_row;
   logic              scrolled;

   tcw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .init_busy  (init_busy),
      .push       (push),
      .push_entry (push_entry)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .init_busy      (init_busy),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_cell_value (cell_value),
      .rsp_cursor_col (cursor_col),
      .rsp_cursor_row (cursor_row),
      .rsp_scrolled   (scrolled)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Pack the result item
   assign rsp_tdata = {(RSP_DATA_W - CELL_W - COL_W - ROW_W - 1)'(0),
                       scrolled, cursor_row, cursor_col, cell_value};

endmodule

/* rtl/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tcw_front.sv */
// Front end: takes request items, holds the color registers, classifies commands.
module tcw_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tcw_pkg::CMD_W-1:0]      req_tuser,
   input  logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]    csr_data,
   input  logic                           queue_full,
   input  logic                           init_busy,
   output logic                           push,
   output tcw_pkg::entry_type             push_entry
);
   import tcw_pkg::*;

   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;
   logic [CMD_W-1:0]   cmd;
   logic [CHAR_W-1:0]  char_code;
   logic [ROW_W-1:0]   read_row;
   logic [COL_W-1:0]   read_col;

   // Unpack request fields
   assign cmd       = req_tuser;
   assign char_code = req_tdata[7:0];
   assign read_row  = req_tdata[12:8];
   assign read_col  = req_tdata[19:13];

   // Color register writes
   assign csr_ready = 1'b1;
   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FG:  fg_in = csr_data;
            CSR_BG:  bg_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   // Accept while the queue has room and the power-up fill is done
   assign req_tready = !queue_full && !init_busy;
   assign push       = req_tvalid && req_tready;

   // Classify the command
   always_comb begin
      push_entry.ch       = char_code;
      push_entry.attr     = {bg_ff, fg_ff};
      push_entry.read_row = read_row;
      push_entry.read_col = read_col;
      push_entry.read_ok  = (read_row < ROW_W'(ROWS)) && (read_col < COL_W'(COLUMNS));
      unique case (cmd)
         CMD_PUT: begin
            if (char_code == CH_NEWLINE) begin
               push_entry.op = OP_NEWLINE;
            end else if (char_code == CH_RETURN) begin
               push_entry.op = OP_RETURN;
            end else begin
               push_entry.op = OP_PUT;
            end
         end
         CMD_CLEAR: push_entry.op = OP_CLEAR;
         CMD_READ:  push_entry.op = OP_READ;
         default:   push_entry.op = OP_NOP;
      endcase
   end

endmodule

/* rtl/tcw_queue.sv */
// Short command queue between the front and back ends.
module tcw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tcw_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output tcw_pkg::entry_type head_entry
);
   import tcw_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/tcw_back.sv */
// Back end: cursor, scroll base, cell writes, fill sweeps and the result register.
`include "text_console_writer_core_assert.svh"

module tcw_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  tcw_pkg::entry_type         head_entry,
   output logic                       pop,
   output logic                       init_busy,
   output logic                       ram_wr_en,
   output logic [tcw_pkg::ADDR_W-1:0] ram_wr_addr,
   output logic [tcw_pkg::CELL_W-1:0] ram_wr_data,
   output logic                       ram_rd_en,
   output logic [tcw_pkg::ADDR_W-1:0] ram_rd_addr,
   input  logic [tcw_pkg::CELL_W-1:0] ram_rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tcw_pkg::CELL_W-1:0] rsp_cell_value,
   output logic [tcw_pkg::COL_W-1:0]  rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]  rsp_cursor_row,
   output logic                       rsp_scrolled
);
   import tcw_pkg::*;

   back_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0]   sweep_last_ff, sweep_last_in;
   logic [CELL_W-1:0]   blank_ff, blank_in;
   logic [COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic [ROW_W-1:0]    base_ff, base_in;
   logic [ADDR_W-1:0]   base_addr_ff, base_addr_in;
   logic                init_done_ff, init_done_in;
   logic                read_ok_ff, read_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   logic [COL_W-1:0]    out_col_ff, out_col_in;
   logic [ROW_W-1:0]    out_row_ff, out_row_in;
   logic                scrolled_ff, scrolled_in;
   logic                rsp_load;
   logic                out_free;
   logic                row_adv;
   logic                scroll;
   logic [ROW_W-1:0]    map_row;
   logic [COL_W-1:0]    map_col;
   logic [ROW_W:0]      row_sum;
   logic [ROW_W-1:0]    phys_row;
   logic [ADDR_W-1:0]   cell_addr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign init_busy = !init_done_ff;

   // Map a logical row onto the rotating store and form the cell address
   always_comb begin
      map_row   = (head_entry.op == OP_READ) ? head_entry.read_row : cur_row_ff;
      map_col   = (head_entry.op == OP_READ) ? head_entry.read_col : cur_col_ff;
      row_sum   = {1'b0, map_row} + {1'b0, base_ff};
      phys_row  = (row_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W + 1)'(ROWS))
                                                  : ROW_W'(row_sum);
      cell_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(map_col);
   end

   // Sequencer: next state, memory access and result
   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      blank_in      = blank_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      base_in       = base_ff;
      base_addr_in  = base_addr_ff;
      init_done_in  = init_done_ff;
      read_ok_in    = read_ok_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sweep_addr_ff;
      ram_wr_data   = blank_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cell_addr;
      pop           = 1'b0;
      rsp_load      = 1'b0;
      row_adv       = 1'b0;
      scroll        = 1'b0;
      cell_in       = '0;
      out_col_in    = cur_col_ff;
      out_row_in    = cur_row_ff;
      scrolled_in   = 1'b0;

      unique case (state_ff)
         BK_SWEEP: begin
            // Blank one cell per cycle
            ram_wr_en = 1'b1;
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in     = BK_RUN;
               init_done_in = 1'b1;
            end else begin
               sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            end
         end

         BK_RUN: begin
            if (head_valid && out_free) begin
               pop = 1'b1;
               case (head_entry.op)
                  OP_PUT: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cell_addr;
                     ram_wr_data = {head_entry.attr, head_entry.ch};
                     if (cur_col_ff == COL_W'(COLUMNS - 1)) begin
                        cur_col_in = '0;
                        row_adv    = 1'b1;
                     end else begin
                        cur_col_in = cur_col_ff + COL_W'(1);
                     end
                  end
                  OP_NEWLINE: begin
                     cur_col_in = '0;
                     row_adv    = 1'b1;
                  end
                  OP_RETURN: begin
                     cur_col_in = '0;
                  end
                  OP_CLEAR: begin
                     cur_col_in    = '0;
                     cur_row_in    = '0;
                     base_in       = '0;
                     base_addr_in  = '0;
                     sweep_addr_in = '0;
                     sweep_last_in = ADDR_W'(CELL_COUNT - 1);
                     blank_in      = {head_entry.attr, CH_BLANK};
                     state_in      = BK_SWEEP;
                  end
                  OP_READ: begin
                     ram_rd_en  = 1'b1;
                     read_ok_in = head_entry.read_ok;
                     state_in   = BK_READ;
                  end
                  default: ;
               endcase

               // Row advance, scrolling by rotating the base row
               if (row_adv) begin
                  if (cur_row_ff == ROW_W'(ROWS - 1)) begin
                     scroll        = 1'b1;
                     sweep_addr_in = base_addr_ff;
                     sweep_last_in = base_addr_ff + ADDR_W'(COLUMNS - 1);
                     blank_in      = {head_entry.attr, CH_BLANK};
                     state_in      = BK_SWEEP;
                     if (base_ff == ROW_W'(ROWS - 1)) begin
                        base_in      = '0;
                        base_addr_in = '0;
                     end else begin
                        base_in      = base_ff + ROW_W'(1);
                        base_addr_in = base_addr_ff + ADDR_W'(COLUMNS);
                     end
                  end else begin
                     cur_row_in = cur_row_ff + ROW_W'(1);
                  end
               end

               if (head_entry.op != OP_READ) begin
                  rsp_load    = 1'b1;
                  out_col_in  = cur_col_in;
                  out_row_in  = cur_row_in;
                  scrolled_in = scroll;
               end
            end
         end

         BK_READ: begin
            // Read data is back; the result slot is free
            rsp_load = 1'b1;
            cell_in  = read_ok_ff ? ram_rd_data : '0;
            state_in = BK_RUN;
         end

         default: state_in = BK_RUN;
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_SWEEP;
         sweep_addr_ff <= '0;
         sweep_last_ff <= ADDR_W'(CELL_COUNT - 1);
         blank_ff      <= {RESET_ATTR, CH_BLANK};
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         base_ff       <= '0;
         base_addr_ff  <= '0;
         init_done_ff  <= 1'b0;
         read_ok_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         blank_ff      <= blank_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         base_ff       <= base_in;
         base_addr_ff  <= base_addr_in;
         init_done_ff  <= init_done_in;
         read_ok_ff    <= read_ok_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         cell_ff     <= cell_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         scrolled_ff <= scrolled_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = cell_ff;
   assign rsp_cursor_col = out_col_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_scrolled   = scrolled_ff;

   `TCW_ASSERT_NOW(a_cursor_range, 1'b1,
      (cur_col_ff < COL_W'(COLUMNS)) && (cur_row_ff < ROW_W'(ROWS)), "cursor out of range")
   `TCW_ASSERT_NOW(a_no_pop_in_sweep, state_ff == BK_SWEEP, !pop, "item taken during sweep")
   `TCW_ASSERT_NEXT(a_read_then_data, pop && (head_entry.op == OP_READ),
      state_ff == BK_READ, "read not followed by data cycle")
   `TCW_ASSERT_NEXT(a_scroll_fills_row, pop && scroll,
      (state_ff == BK_SWEEP) && (sweep_addr_ff == $past(base_addr_ff)),
      "scroll did not start a row fill")

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the text console writer: screen predictor, stream drivers, checks.
module tb_top;
   import tcw_pkg::*;

   // Command code the block leaves unused; it must answer with a zero cell
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // Request as the testbench keeps it: cmd in the low bits, then the tdata fields
   localparam int REQ_ITEM_W    = REQ_DATA_W + CMD_W;
   // A clear sweeps every cell in turn; every wait leaves room for a whole sweep
   localparam int SETTLE_CYCLES = CELL_COUNT + 100;
   localparam int PHASE_ITEMS   = 240;
   localparam int PHASE_COUNT   = 6;
   localparam int CLEAR_CAP     = 30;
   localparam int REPORT_LIMIT  = 10;

   // One response as the block reports it
   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic              scrolled;
   } console_rsp_type;

   // Screen tracker: mirrors the cell store, cursor and colors, queues predicted responses
   class console_tracker;
      logic [CELL_W-1:0]  screen[CELL_COUNT];
      int                 cur_col;
      int                 cur_row;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      console_rsp_type    pending[$];
      int                 failures;

      function new();
         fg = FG_RESET;
         bg = BG_RESET;
         cur_col = 0;
         cur_row = 0;
         failures = 0;
         foreach (screen[i]) screen[i] = {RESET_ATTR, CH_BLANK};
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
         if (idx == CSR_FG) fg = val;
         else if (idx == CSR_BG) bg = val;
      endfunction

      function logic [CELL_W-1:0] colored(logic [CHAR_W-1:0] ch);
         return {bg, fg, ch};
      endfunction

      function void fail(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("%0t: mismatch: %s", $time, msg);
      endfunction

      // Move the cursor down one row; scroll the store when already on the bottom row
      function logic next_row();
         if (cur_row + 1 < ROWS) begin
            cur_row++;
            return 1'b0;
         end
         for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
         for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) screen[i] = colored(CH_BLANK);
         return 1'b1;
      endfunction

      // Apply one accepted request and queue the response it must produce
      function void note_request(logic [REQ_ITEM_W-1:0] word);
         logic [CMD_W-1:0]  cmd;
         logic [CHAR_W-1:0] ch;
         logic [ROW_W-1:0]  rrow;
         logic [COL_W-1:0]  rcol;
         console_rsp_type   rsp;
         cmd  = word[1:0];
         ch   = word[9:2];
         rrow = word[14:10];
         rcol = word[21:15];
         rsp  = '0;
         case (cmd)
            CMD_PUT: begin
               if (ch == CH_NEWLINE) begin
                  cur_col = 0;
                  rsp.scrolled = next_row();
               end else if (ch == CH_RETURN) begin
                  cur_col = 0;
               end else begin
                  screen[cur_row * COLUMNS + cur_col] = colored(ch);
                  cur_col++;
                  if (cur_col >= COLUMNS) begin
                     cur_col = 0;
                     rsp.scrolled = next_row();
                  end
               end
            end
            CMD_CLEAR: begin
               foreach (screen[i]) screen[i] = colored(CH_BLANK);
               cur_col = 0;
               cur_row = 0;
            end
            CMD_READ: begin
               if (rrow < ROWS && rcol < COLUMNS) rsp.cell_value = screen[rrow * COLUMNS + rcol];
            end
            default: ;
         endcase
         rsp.cursor_col = cur_col[COL_W-1:0];
         rsp.cursor_row = cur_row[ROW_W-1:0];
         pending.push_back(rsp);
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(logic [RSP_DATA_W-1:0] word);
         console_rsp_type got;
         console_rsp_type want;
         got.cell_value = word[15:0];
         got.cursor_col = word[22:16];
         got.cursor_row = word[27:23];
         got.scrolled   = word[28];
         if (pending.size() == 0) begin
            fail($sformatf("response %h with nothing outstanding", word));
            return;
         end
         want = pending.pop_front();
         if (got != want)
            fail($sformatf({"expected cell %h col %0d row %0d scrolled %0d, ",
                            "got cell %h col %0d row %0d scrolled %0d"},
                           want.cell_value, want.cursor_col, want.cursor_row, want.scrolled,
                           got.cell_value, got.cursor_col, got.cursor_row, got.scrolled));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [CMD_W-1:0]        req_tuser = '0;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [COLOR_W-1:0]      csr_data = '0;

   console_tracker tracker = new();
   int burst_left = 0;
   int clears_sent = 0;
   int rx_mode = 0;
   int rx_left = 0;
   logic [3:0] rx_tick = '0;

   text_console_writer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Receiver: switch between always ready, coin flips, one in four, and long stalls
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_left <= $urandom_range(32, 400);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_tick <= rx_tick + 4'd1;
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (rx_tick[1:0] == 2'b11);
         default: rsp_tready <= (rx_tick >= 4'd12);
      endcase
   end

   // Watch all three channels; a config write lands before any request of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_register(csr_index, csr_data);
         if (req_tvalid && req_tready) tracker.note_request({req_tdata, req_tuser});
         if (rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
      end
   end

   function automatic logic [REQ_ITEM_W-1:0] pack_request(logic [CMD_W-1:0] cmd,
         logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] rrow, logic [COL_W-1:0] rcol);
      return {(REQ_ITEM_W - CMD_W - CHAR_W - ROW_W - COL_W)'(0), rcol, rrow, ch, cmd};
   endfunction

   // Hand one item to the block, opening a random gap whenever a burst runs out
   task automatic send_item(input logic [REQ_ITEM_W-1:0] word);
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
      end
      req_tuser  <= word[CMD_W-1:0];
      req_tdata  <= word[REQ_ITEM_W-1:CMD_W];
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // Hold the input off until every outstanding response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending.size() != 0) @(posedge clock);
   endtask

   // Write both color registers while the block is idle
   task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      logic [CSR_IDX_W-1:0] idx[2];
      logic [COLOR_W-1:0]   val[2];
      idx[0] = CSR_FG;
      idx[1] = CSR_BG;
      val[0] = fg;
      val[1] = bg;
      for (int i = 0; i < 2; i++) begin
         csr_index <= idx[i];
         csr_data  <= val[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly text with line breaks and reads near the cursor; some noise and stray commands
   function automatic logic [REQ_ITEM_W-1:0] random_request();
      int pick;
      int sub;
      logic [CHAR_W-1:0] ch;
      logic [ROW_W-1:0]  rrow;
      logic [COL_W-1:0]  rcol;
      pick = $urandom_range(0, 99);
      ch   = CHAR_W'($urandom_range(0, 255));
      rrow = ROW_W'($urandom_range(0, 31));
      rcol = COL_W'($urandom_range(0, 127));
      if (pick < 92 && pick >= 62) begin
         sub = $urandom_range(0, 99);
         if (sub < 50) begin
            rrow = (tracker.cur_row > 0 && $urandom_range(0, 1)) ? ROW_W'(tracker.cur_row - 1)
                                                                 : ROW_W'(tracker.cur_row);
            rcol = COL_W'($urandom_range(0, COLUMNS - 1));
         end else if (sub < 85) begin
            rrow = ROW_W'($urandom_range(0, ROWS - 1));
            rcol = COL_W'($urandom_range(0, COLUMNS - 1));
         end
         return pack_request(CMD_READ, ch, rrow, rcol);
      end
      if (pick >= 92 && pick < 95) return pack_request(CMD_UNUSED, ch, rrow, rcol);
      if (pick == 95 && clears_sent < CLEAR_CAP) begin
         clears_sent++;
         return pack_request(CMD_CLEAR, ch, rrow, rcol);
      end
      sub = $urandom_range(0, 99);
      if (sub < 14) ch = CH_NEWLINE;
      else if (sub < 18) ch = CH_RETURN;
      else if (sub < 70) ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
      return pack_request(CMD_PUT, ch, rrow, rcol);
   endfunction

   // Stimulus: reset, directed items with reset colors, then random phases per color setting
   initial begin
      logic [COLOR_W-1:0] fg_set[PHASE_COUNT];
      logic [COLOR_W-1:0] bg_set[PHASE_COUNT];
      fg_set = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd0, 4'd0};
      bg_set = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd0, 4'd0};
      fg_set[4] = COLOR_W'($urandom_range(0, 15));
      bg_set[4] = COLOR_W'($urandom_range(0, 15));
      fg_set[5] = COLOR_W'($urandom_range(0, 15));
      bg_set[5] = COLOR_W'($urandom_range(0, 15));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset contents, reads outside the store, the unused command
      send_item(pack_request(CMD_READ, 8'h00, 5'd0, 7'd0));
      send_item(pack_request(CMD_READ, 8'hff, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1)));
      send_item(pack_request(CMD_READ, 8'h00, ROW_W'(ROWS), 7'd0));
      send_item(pack_request(CMD_READ, 8'h00, 5'd0, COL_W'(COLUMNS)));
      send_item(pack_request(CMD_READ, 8'hff, 5'd31, 7'd127));
      send_item(pack_request(CMD_UNUSED, 8'hff, 5'd31, 7'd127));
      // Extreme characters, high bytes must not leak into the attribute
      send_item(pack_request(CMD_PUT, 8'h00, 5'd31, 7'd127));
      send_item(pack_request(CMD_PUT, 8'hff, 5'd0, 7'd0));
      send_item(pack_request(CMD_PUT, 8'h80, 5'd0, 7'd0));
      send_item(pack_request(CMD_PUT, "A", 5'd0, 7'd0));
      // Carriage return goes back to column 0 and overwrites there
      send_item(pack_request(CMD_PUT, CH_RETURN, 5'd0, 7'd0));
      send_item(pack_request(CMD_PUT, 8'h7f, 5'd0, 7'd0));
      send_item(pack_request(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0));
      send_item(pack_request(CMD_READ, 8'h00, 5'd0, 7'd0));
      send_item(pack_request(CMD_READ, 8'h00, 5'd0, 7'd1));
      send_item(pack_request(CMD_READ, 8'h00, 5'd0, 7'd2));
      send_item(pack_request(CMD_READ, 8'h00, 5'd0, 7'd3));
      // Clear blanks with the current attribute and homes the cursor
      send_item(pack_request(CMD_CLEAR, 8'hff, 5'd31, 7'd127));
      send_item(pack_request(CMD_READ, 8'h00, 5'd0, 7'd2));
      send_item(pack_request(CMD_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1)));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         repeat (SETTLE_CYCLES) @(posedge clock);
         set_colors(fg_set[p], bg_set[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_item(random_request());
            if ($urandom_range(0, 149) == 0) drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending.size() != 0) tracker.fail("responses still outstanding at end");
      if (tracker.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: report a failure and stop if the stimulus never finishes
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
